/* rtl/core/opc_pkg.sv */
package opc_pkg;

  localparam int MAX_PATTERN_DEF = 64;

  typedef enum logic {
    OP_PATTERN = 1'b0,
    OP_TEXT    = 1'b1
  } op_t;

  // one input beat as held in the input stage
  typedef struct packed {
    op_t        op;
    logic [7:0] symbol;
    logic       final_byte;
  } item_t;

  // matcher verdict for the beat being processed
  typedef struct packed {
    logic hit;        // window equals pattern (or pattern empty)
    logic empty_pat;  // no pattern bytes held
    logic overflow;   // bytes dropped from current pattern
  } match_t;

endpackage

/* rtl/core/opc_matcher.sv */
module opc_matcher #(
  parameter int MAX_PATTERN = opc_pkg::MAX_PATTERN_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step_en,
  input  opc_pkg::item_t  item,
  output opc_pkg::match_t verdict
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);

  // pattern held reversed: pat_r[k] is the byte that must sit k beats back
  logic [7:0]       pat_r   [MAX_PATTERN];
  logic [7:0]       pat_nxt [MAX_PATTERN];
  logic [7:0]       win_r   [MAX_PATTERN];
  logic [7:0]       win_nxt [MAX_PATTERN];
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] seen_r, seen_nxt;
  logic             closed_r, closed_nxt;
  logic             ovf_r, ovf_nxt;

  logic [LEN_W-1:0] len_base;
  logic [LEN_W-1:0] seen_inc;
  logic [MAX_PATTERN-1:0] eq;

  // shifted window and saturated fill level for a text beat
  always_comb begin
    win_nxt[0] = item.symbol;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_nxt[k] = win_r[k-1];
    end
    seen_inc = (seen_r == LEN_MAX) ? seen_r : seen_r + LEN_W'(1);
  end

  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      eq[k] = (LEN_W'(k) >= len_r) || (win_nxt[k] == pat_r[k]);
    end
    verdict.empty_pat = (len_r == '0);
    verdict.hit       = verdict.empty_pat || ((seen_inc >= len_r) && (&eq));
    verdict.overflow  = ovf_r;
  end

  always_comb begin
    pat_nxt    = pat_r;
    len_nxt    = len_r;
    seen_nxt   = seen_r;
    closed_nxt = closed_r;
    ovf_nxt    = ovf_r;
    len_base   = closed_r ? '0 : len_r;
    if (step_en) begin
      case (item.op)
        opc_pkg::OP_PATTERN: begin
          if (closed_r) begin
            ovf_nxt = 1'b0;
          end
          len_nxt = len_base;
          if (len_base < LEN_MAX) begin
            pat_nxt[0] = item.symbol;
            for (int k = 1; k < MAX_PATTERN; k++) begin
              pat_nxt[k] = pat_r[k-1];
            end
            len_nxt = len_base + LEN_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          closed_nxt = item.final_byte;
        end
        opc_pkg::OP_TEXT: begin
          closed_nxt = 1'b1;
          seen_nxt   = item.final_byte ? '0 : seen_inc;
        end
        default: begin
          closed_nxt = closed_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      seen_r   <= '0;
      closed_r <= 1'b1;
      ovf_r    <= 1'b0;
    end else begin
      len_r    <= len_nxt;
      seen_r   <= seen_nxt;
      closed_r <= closed_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  // window contents past the fill level are never compared
  always_ff @(posedge clk) begin
    pat_r <= pat_nxt;
    if (step_en && (item.op == opc_pkg::OP_TEXT)) begin
      win_r <= win_nxt;
    end
  end

endmodule

/* rtl/core/overlapping_pattern_counter_top.sv */
// channel | dir | beat contents
// in_     | in  | tdata = symbol, tuser = operation, tlast = final_byte
// out_    | out | tdata = occurrences, tuser = pattern_overflow
//
// One beat per cycle sustained while no held result stalls the input stage; the final
// text beat is registered in the input stage, then its result in the output register.
// The match is a parallel compare of the whole window against the pattern.
// Reset empties the pattern, closes it and clears the text state.
// A held result stalls the input stage only when the next beat also ends a text.
module overlapping_pattern_counter_top #(
  parameter int MAX_PATTERN = opc_pkg::MAX_PATTERN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] symbol
  input  logic        in_tuser,   // [0] operation
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] occurrences
  output logic        out_tuser   // [0] pattern_overflow
);

  opc_pkg::item_t  s1_item_r;
  logic            s1_valid_r;
  opc_pkg::match_t verdict;
  logic            out_free;
  logic            s1_ends_text;
  logic            drain;
  logic [31:0]     count_r, count_nxt;
  logic [1:0]      inc;
  logic [32:0]     sum;
  logic [31:0]     total;
  logic            out_valid_r;
  logic [31:0]     out_data_r;
  logic            out_ovf_r;

  assign out_free     = !out_valid_r || out_tready;
  assign s1_ends_text = (s1_item_r.op == opc_pkg::OP_TEXT) && s1_item_r.final_byte;
  assign drain        = s1_valid_r && (out_free || !s1_ends_text);
  assign in_tready    = !s1_valid_r || drain;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r.op         <= opc_pkg::op_t'(in_tuser);
      s1_item_r.symbol     <= in_tdata;
      s1_item_r.final_byte <= in_tlast;
    end
  end

  opc_matcher #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_matcher (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (drain),
    .item    (s1_item_r),
    .verdict (verdict)
  );

  // empty pattern: the finished text adds one more
  always_comb begin
    inc   = {1'b0, verdict.hit} + {1'b0, s1_item_r.final_byte && verdict.empty_pat};
    sum   = {1'b0, count_r} + {31'd0, inc};
    total = sum[32] ? '1 : sum[31:0];
    count_nxt = count_r;
    if (drain && (s1_item_r.op == opc_pkg::OP_TEXT)) begin
      count_nxt = s1_item_r.final_byte ? '0 : total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (drain && s1_ends_text) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (drain && s1_ends_text) begin
      out_data_r <= total;
      out_ovf_r  <= verdict.overflow;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ovf_r;

  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    drain && s1_ends_text |=> out_valid_r)
    else $error("final text beat did not load the output register");

  a_end_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    drain && s1_ends_text |=> count_r == '0)
    else $error("count not cleared after end of text");

  a_pattern_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    drain && (s1_item_r.op == opc_pkg::OP_PATTERN) |=> count_r == $past(count_r))
    else $error("pattern beat changed the count");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !(drain && s1_ends_text))
    else $error("held result overwritten");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && s1_ends_text && out_valid_r)
    else $error("input stalled without a held result");

endmodule

/* tb/sv/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXP       = opc_pkg::MAX_PATTERN_DEF;
  localparam int RAND_BEATS = 530;
  localparam int STALL_MAX  = 2000;
  localparam int NUM_ROWS   = 21;

  typedef struct packed {
    logic [31:0] occ;
    logic        ovf;
  } text_result_t;

  // one directed row; last and the typed result apply to the final repeat only
  typedef struct packed {
    opc_pkg::op_t op;
    logic [7:0]   sym;
    logic         last;
    logic [7:0]   reps;
    logic         typed;
    logic [31:0]  occ;
    logic         ovf;
  } dir_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;  // [7:0] symbol
  logic        in_tuser   = 1'b0;   // [0] operation
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;           // [31:0] occurrences
  logic        out_tuser;           // [0] pattern_overflow

  overlapping_pattern_counter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #2 clk = ~clk;

  // predictor state
  logic [7:0]  pat_mem [MAXP] = '{default: 8'h00};
  logic [7:0]  win     [MAXP] = '{default: 8'h00};  // win[0] is the newest text byte
  int unsigned pat_len  = 0;
  logic        pat_done = 1'b1;
  logic        pat_ovf  = 1'b0;
  int unsigned seen     = 0;
  logic [31:0] hits     = '0;

  text_result_t count_q[$];
  text_result_t got_r;
  int           fail_cnt = 0;
  int           sent = 0;
  int           idle_cycles = 0;
  logic         no_idle = 1'b0;
  dir_row_t     dir_tab [NUM_ROWS];

  function automatic logic scan_beat(input opc_pkg::op_t op, input logic [7:0] sym,
                                     input logic last, output text_result_t r);
    int   i;
    logic hit;
    r = '0;
    if (op == opc_pkg::OP_PATTERN) begin
      if (pat_done) begin
        pat_len  = 0;
        pat_ovf  = 1'b0;
        pat_done = 1'b0;
      end
      if (pat_len < MAXP) begin
        pat_mem[pat_len] = sym;
        pat_len++;
      end else begin
        pat_ovf = 1'b1;
      end
      if (last) pat_done = 1'b1;
      return 1'b0;
    end
    pat_done = 1'b1;
    for (i = MAXP - 1; i > 0; i--) win[i] = win[i-1];
    win[0] = sym;
    if (seen < MAXP) seen++;
    // an empty pattern matches at every byte
    hit = 1'b1;
    if (pat_len != 0) begin
      if (seen < pat_len) begin
        hit = 1'b0;
      end else begin
        for (i = 0; i < pat_len; i++)
          if (pat_mem[i] != win[pat_len-1-i]) hit = 1'b0;
      end
    end
    if (hit && hits != '1) hits++;
    if (!last) return 1'b0;
    if (pat_len == 0 && hits != '1) hits++;
    r.occ = hits;
    r.ovf = pat_ovf;
    for (i = 0; i < MAXP; i++) win[i] = 8'h00;
    seen = 0;
    hits = '0;
    return 1'b1;
  endfunction

  task automatic drive_beat(input opc_pkg::op_t op, input logic [7:0] sym, input logic last,
                            input logic typed, input logic [31:0] occ_t, input logic ovf_t);
    text_result_t r;
    logic         done;
    if (!no_idle)
      while ($urandom_range(99) < 25) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= sym;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    done = scan_beat(op, sym, last, r);
    if (done) begin
      if (typed) begin
        r.occ = occ_t;
        r.ovf = ovf_t;
      end
      count_q.push_back(r);
    end
    sent++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_tready <= no_idle || ($urandom_range(99) >= 25);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (count_q.size() == 0) begin
        $error("unexpected result beat: occurrences=%0d pattern_overflow=%0d",
               out_tdata, out_tuser);
        fail_cnt++;
      end else begin
        got_r = count_q.pop_front();
        if (out_tdata !== got_r.occ) begin
          $error("occurrences: expected %0d, got %0d", got_r.occ, out_tdata);
          fail_cnt++;
        end
        if (out_tuser !== got_r.ovf) begin
          $error("pattern_overflow: expected %0d, got %0d", got_r.ovf, out_tuser);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_MAX) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int          r;
    int          k;
    int          s;
    int          n;
    int          plen;
    int          dir_beats;
    logic        open_pat;
    logic        paused;
    logic [7:0]  alpha [3];
    logic [7:0]  gen_pat[$];
    logic [7:0]  txt[$];

    paused = 1'b0;
    for (k = 0; k < 3; k++) alpha[k] = 8'($urandom);

    dir_tab = '{
      // empty pattern after reset: text length plus one
      '{opc_pkg::OP_TEXT,    8'h41, 1'b0, 8'd1,  1'b0, 32'd0, 1'b0},
      '{opc_pkg::OP_TEXT,    8'h42, 1'b0, 8'd1,  1'b0, 32'd0, 1'b0},
      '{opc_pkg::OP_TEXT,    8'h43, 1'b1, 8'd1,  1'b1, 32'd4, 1'b0},
      // zero bytes, overlapping matches
      '{opc_pkg::OP_PATTERN, 8'h00, 1'b0, 8'd1,  1'b0, 32'd0, 1'b0},
      '{opc_pkg::OP_PATTERN, 8'h00, 1'b1, 8'd1,  1'b0, 32'd0, 1'b0},
      '{opc_pkg::OP_TEXT,    8'h00, 1'b1, 8'd3,  1'b1, 32'd2, 1'b0},
      // pattern too long: two bytes dropped
      '{opc_pkg::OP_PATTERN, 8'hFF, 1'b1, 8'd66, 1'b0, 32'd0, 1'b0},
      '{opc_pkg::OP_TEXT,    8'hFF, 1'b1, 8'd64, 1'b1, 32'd1, 1'b1},
      '{opc_pkg::OP_TEXT,    8'hFF, 1'b1, 8'd65, 1'b1, 32'd2, 1'b1},
      // open pattern closed by text
      '{opc_pkg::OP_PATTERN, 8'hAB, 1'b0, 8'd1,  1'b0, 32'd0, 1'b0},
      '{opc_pkg::OP_TEXT,    8'hAB, 1'b0, 8'd1,  1'b0, 32'd0, 1'b0},
      '{opc_pkg::OP_TEXT,    8'h55, 1'b0, 8'd1,  1'b0, 32'd0, 1'b0},
      '{opc_pkg::OP_TEXT,    8'hAB, 1'b1, 8'd1,  1'b1, 32'd2, 1'b0},
      '{opc_pkg::OP_PATTERN, 8'h80, 1'b1, 8'd1,  1'b0, 32'd0, 1'b0},
      '{opc_pkg::OP_TEXT,    8'h7F, 1'b1, 8'd1,  1'b1, 32'd0, 1'b0},
      '{opc_pkg::OP_PATTERN, 8'h01, 1'b0, 8'd1,  1'b0, 32'd0, 1'b0},
      '{opc_pkg::OP_PATTERN, 8'h02, 1'b1, 8'd1,  1'b0, 32'd0, 1'b0},
      '{opc_pkg::OP_TEXT,    8'h01, 1'b0, 8'd1,  1'b0, 32'd0, 1'b0},
      '{opc_pkg::OP_TEXT,    8'h02, 1'b0, 8'd1,  1'b0, 32'd0, 1'b0},
      '{opc_pkg::OP_TEXT,    8'h01, 1'b0, 8'd1,  1'b0, 32'd0, 1'b0},
      '{opc_pkg::OP_TEXT,    8'h02, 1'b1, 8'd1,  1'b0, 32'd0, 1'b0}
    };

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (r = 0; r < NUM_ROWS; r++)
      for (k = 0; k < dir_tab[r].reps; k++)
        drive_beat(dir_tab[r].op, dir_tab[r].sym,
                   dir_tab[r].last && (k == dir_tab[r].reps - 1),
                   dir_tab[r].typed && (k == dir_tab[r].reps - 1),
                   dir_tab[r].occ, dir_tab[r].ovf);
    dir_beats = sent;

    while (sent < dir_beats + RAND_BEATS) begin
      if (!paused && sent >= dir_beats + RAND_BEATS / 2) begin
        // hold off until the result channel drains
        paused = 1'b1;
        in_tvalid <= 1'b0;
        wait (count_q.size() == 0);
        @(negedge clk);
      end
      no_idle = (sent >= dir_beats + 320) && (sent < dir_beats + 450);

      if ($urandom_range(99) < 8) begin
        n = $urandom_range(6, 1);
        repeat (n)
          drive_beat(opc_pkg::op_t'($urandom_range(1)), 8'($urandom),
                     1'($urandom_range(1)), 1'b0, '0, 1'b0);
      end else begin
        if (gen_pat.size() == 0 || $urandom_range(99) < 70) begin
          for (k = 0; k < 3; k++) alpha[k] = 8'($urandom);
          gen_pat.delete();
          plen = ($urandom_range(19) == 0) ? $urandom_range(70, 60) : $urandom_range(5, 1);
          for (k = 0; k < plen; k++) gen_pat.push_back(alpha[$urandom_range(1)]);
          open_pat = ($urandom_range(9) == 0);
          for (k = 0; k < plen; k++)
            drive_beat(opc_pkg::OP_PATTERN, gen_pat[k], (k == plen - 1) && !open_pat,
                       1'b0, '0, 1'b0);
        end
        n = $urandom_range(3, 1);
        repeat (n) begin
          txt.delete();
          s = $urandom_range(4, 1);
          repeat (s) begin
            if ($urandom_range(2) == 0) begin
              for (k = 0; k < gen_pat.size() && k < MAXP; k++) txt.push_back(gen_pat[k]);
            end else begin
              repeat ($urandom_range(6)) txt.push_back(alpha[$urandom_range(2)]);
            end
          end
          if (txt.size() == 0) txt.push_back(alpha[$urandom_range(2)]);
          for (k = 0; k < txt.size(); k++)
            drive_beat(opc_pkg::OP_TEXT, txt[k], k == txt.size() - 1, 1'b0, '0, 1'b0);
        end
      end
    end
    no_idle = 1'b0;
    in_tvalid <= 1'b0;

    wait (count_q.size() == 0);
    repeat (8) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
